// File: rtl/ssetc_pkg.sv
// Shared widths and control/status structs for the subarray sum target counter.
package ssetc_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ELEM_W       = 32;
  localparam int SUM_W        = ELEM_W + $clog2(MAX_ELEMENTS);
  localparam int WANT_W       = SUM_W + 1;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int TALLY_W      = 20;
  localparam int TSUM_W       = TALLY_W + 1;
  localparam int IN_TDATA_W   = ((ELEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((TALLY_W + 7) / 8) * 8;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  typedef struct packed {
    logic acc;
    logic want;
    logic scan;
    logic commit;
    logic drop;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic scan_last;
  } sts_t;

endpackage

// File: rtl/subarray_sum_equals_target_counter_unit.sv
// Top level: stream ports, target register, sequencer and output register.
//
// Counts contiguous runs of a signed element stream that sum to target_sum.
// Input beats arrive on in_* (element in in_tdata, end of sequence on
// in_tlast). Each accepted beat gives exactly one output beat on out_*:
// the running match total, the last flag echoed on out_tlast, and
// out_tuser set when the element was dropped because the prefix store
// already holds MAX_ELEMENTS sums.
// target_sum is written through cfg_valid/cfg_data; cfg_ready is always high.
// An element taken into the store goes through an add, a subtract, a
// compare against the empty prefix and each stored sum, and a commit;
// a dropped element goes straight to the commit step. The next beat is taken
// when the result has moved into the output register, so one result may
// wait there while the next element is scanned. The single compare unit
// and the store's one read port set the time, one stored sum per cycle.
// Reset clears the running sum, store fill count, total and target.
// A stalled receiver holds the output beat; a finished item then waits
// in the commit step and in_tready stays low until out_tready frees it.
module subarray_sum_equals_target_counter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // element [31:0]
  input  logic [ssetc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // match_total [19:0], zero [23:20]
  output logic [ssetc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // capacity_exceeded [0]
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [ssetc_pkg::ELEM_W-1:0]         cfg_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WANT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           drop_r, drop_nxt;
  logic                           last_r, last_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ssetc_pkg::TALLY_W-1:0]  out_total_r, out_total_nxt;
  logic                           out_last_r, out_last_nxt;
  logic                           out_drop_r, out_drop_nxt;
  logic [ssetc_pkg::ELEM_W-1:0]   target_r;

  ssetc_pkg::ctrl_t               ctrl;
  ssetc_pkg::sts_t                sts;
  logic [ssetc_pkg::TALLY_W-1:0]  total;
  logic                           in_fire;
  logic                           load;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign load       = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ssetc_pkg::OUT_TDATA_W'(out_total_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target_r <= cfg_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    drop_nxt      = drop_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    ctrl          = '0;
    ctrl.drop     = drop_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_tlast;
          if (sts.full) begin
            drop_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            drop_nxt  = 1'b0;
            ctrl.acc  = 1'b1;
            state_nxt = S_WANT;
          end
        end
      end
      S_WANT: begin
        ctrl.want = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          ctrl.commit   = 1'b1;
          ctrl.clear    = last_r;
          out_valid_nxt = 1'b1;
          out_total_nxt = total;
          out_last_nxt  = last_r;
          out_drop_nxt  = drop_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      drop_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drop_r      <= drop_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  ssetc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .element (in_tdata[ssetc_pkg::ELEM_W-1:0]),
    .target  (target_r),
    .sts     (sts),
    .total   (total)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken again before the item finished");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_r) |=> !sts.full)
    else $error("store not cleared after final element");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !sts.full) |=> (state_r == S_WANT) && !drop_r)
    else $error("element dropped while store had room");

  a_drop_holds_total: assert property (@(posedge clk) disable iff (!rst_n)
    (load && drop_r) |-> !ctrl.acc)
    else $error("dropped element changed the running sum");

endmodule

// File: rtl/ssetc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssetc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ssetc_dp.sv
// Datapath: running sum, shared adder, prefix store and the scan compare unit.
module ssetc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssetc_pkg::ctrl_t                  ctrl,
  input  logic [ssetc_pkg::ELEM_W-1:0]      element,
  input  logic [ssetc_pkg::ELEM_W-1:0]      target,
  output ssetc_pkg::sts_t                   sts,
  output logic [ssetc_pkg::TALLY_W-1:0]     total
);

  logic [ssetc_pkg::SUM_W-1:0]   rs_r, rs_nxt;
  logic [ssetc_pkg::WANT_W-1:0]  want_r, want_nxt;
  logic [ssetc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ssetc_pkg::CNT_W-1:0]   hits_r, hits_nxt;
  logic [ssetc_pkg::CNT_W-1:0]   entries_r, entries_nxt;
  logic [ssetc_pkg::TALLY_W-1:0] tally_r, tally_nxt;

  logic [ssetc_pkg::WANT_W-1:0]  add_a, add_b, add_sum;
  logic [ssetc_pkg::WANT_W-1:0]  elem_x, targ_x, cmp_op;
  logic [ssetc_pkg::SUM_W-1:0]   rd_data;
  logic [ssetc_pkg::TSUM_W-1:0]  tsum;
  logic                          hit;
  logic                          ram_we;

  assign elem_x = {{(ssetc_pkg::WANT_W-ssetc_pkg::ELEM_W){element[ssetc_pkg::ELEM_W-1]}},
                   element};
  assign targ_x = {{(ssetc_pkg::WANT_W-ssetc_pkg::ELEM_W){target[ssetc_pkg::ELEM_W-1]}},
                   target};

  // shared adder: rs + element, or rs - target
  assign add_a   = {rs_r[ssetc_pkg::SUM_W-1], rs_r};
  assign add_b   = ctrl.acc ? elem_x : ~targ_x;
  assign add_sum = add_a + add_b + ssetc_pkg::WANT_W'(!ctrl.acc);

  // shared compare unit: empty prefix first, then each stored prefix
  assign cmp_op = (cnt_r == '0) ? '0 :
                  {rd_data[ssetc_pkg::SUM_W-1], rd_data};
  assign hit    = (want_r == cmp_op);

  assign tsum  = {1'b0, tally_r} + ssetc_pkg::TSUM_W'(hits_r);
  assign total = ctrl.drop ? tally_r :
                 (tsum[ssetc_pkg::TALLY_W] ? ssetc_pkg::TALLY_MAX
                                           : tsum[ssetc_pkg::TALLY_W-1:0]);

  assign ram_we        = ctrl.commit && !ctrl.drop;
  assign sts.full      = (entries_r >= ssetc_pkg::CNT_W'(ssetc_pkg::MAX_ELEMENTS));
  assign sts.scan_last = (cnt_r == entries_r);

  ssetc_ram #(
    .WIDTH (ssetc_pkg::SUM_W),
    .DEPTH (ssetc_pkg::MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entries_r[ssetc_pkg::ADDR_W-1:0]),
    .wdata (rs_r),
    .raddr (cnt_r[ssetc_pkg::ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    rs_nxt      = rs_r;
    want_nxt    = want_r;
    cnt_nxt     = cnt_r;
    hits_nxt    = hits_r;
    entries_nxt = entries_r;
    tally_nxt   = tally_r;
    if (ctrl.acc) begin
      rs_nxt = add_sum[ssetc_pkg::SUM_W-1:0];
    end
    if (ctrl.want) begin
      want_nxt = add_sum;
      cnt_nxt  = '0;
      hits_nxt = '0;
    end
    if (ctrl.scan) begin
      cnt_nxt = cnt_r + ssetc_pkg::CNT_W'(1);
      if (hit) begin
        hits_nxt = hits_r + ssetc_pkg::CNT_W'(1);
      end
    end
    if (ram_we) begin
      entries_nxt = entries_r + ssetc_pkg::CNT_W'(1);
      tally_nxt   = total;
    end
    if (ctrl.commit && ctrl.clear) begin
      rs_nxt      = '0;
      entries_nxt = '0;
      tally_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r      <= '0;
      entries_r <= '0;
      tally_r   <= '0;
      cnt_r     <= '0;
      hits_r    <= '0;
    end else begin
      rs_r      <= rs_nxt;
      entries_r <= entries_nxt;
      tally_r   <= tally_nxt;
      cnt_r     <= cnt_nxt;
      hits_r    <= hits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r <= want_nxt;
  end

endmodule
